// File: src/box_blur_3x3_stream_defines.svh
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_STREAM_DEFINES_SVH
`define BOX_BLUR_3X3_STREAM_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define BB3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define BB3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, constants and helpers of the 3x3 box blur stream.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam int PIX_BITS   = 24;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd1024;

    // register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // item command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic capture;
        logic shift;
        logic sum;
        logic mul;
        logic load;
    } t_bb3_cmd;

    typedef struct packed {
        logic pend_zero;
        logic emit_now;
        logic out_free;
    } t_bb3_status;

    // floor(65536 / (2*count)) for the legal neighbour counts
    function automatic logic [15:0] bb3_recip(input logic [3:0] cnt);
        logic [15:0] m;
        case (cnt)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10922;
            4'd4:    m = 16'd8192;
            4'd6:    m = 16'd5461;
            4'd9:    m = 16'd3640;
            default: m = 16'd0;
        endcase
        return m;
    endfunction

endpackage

// File: src/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: accept, window shift, sum, reciprocal multiply, output load.
// ----------------------------------------------------------------------------
module bb3_ctrl
    import bb3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_cmd,
    output logic        o_stall,
    input  t_bb3_status i_status,
    output t_bb3_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_MUL,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                // a drain with nothing owed is taken and dropped
                if (i_valid && !(i_cmd == CMD_DRAIN && i_status.pend_zero)) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.emit_now ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/bb3_datapath.sv
// ----------------------------------------------------------------------------
// bb3_datapath
// Line stores, 3x3 window, frame counters, rounded-mean divider, output reg.
// ----------------------------------------------------------------------------
module bb3_datapath
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output logic [CFG_W_BITS-1:0] o_frame_width,
    output logic [CFG_H_BITS-1:0] o_frame_height,
    input  logic                  i_cmd,
    input  logic [7:0]            i_in_red,
    input  logic [7:0]            i_in_green,
    input  logic [7:0]            i_in_blue,
    input  t_bb3_cmd              i_ctl,
    output t_bb3_status           o_status,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic                  o_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [31:0] MAXW32 = MAX_WIDTH;
    localparam logic [31:0] MAXH32 = HEIGHT_LIMIT;

    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic [CFG_W_BITS-1:0] w_eff;
    logic [CFG_H_BITS-1:0] h_eff;

    logic [PIX_BITS-1:0] r_mem_up [MAX_WIDTH];
    logic [PIX_BITS-1:0] r_mem_lo [MAX_WIDTH];
    logic [PIX_BITS-1:0] r_up_rd, r_lo_rd, r_px;
    logic                r_drain;
    logic [PIX_BITS-1:0] r_win [3][3];

    logic [AW-1:0]         r_tap;
    logic [CFG_W_BITS:0]   r_pend;
    logic [CFG_W_BITS:0]   lag;
    logic [CFG_W_BITS-1:0] r_icol, r_ocol, r_ecol;
    logic [CFG_H_BITS-1:0] r_irow, r_orow, r_erow;

    logic [12:0] r_n [3];
    logic [12:0] r_q [3];
    logic [12:0] r_n2 [3];
    logic [4:0]  r_d, r_d2;
    logic [15:0] r_m;
    logic        r_fe, r_fe2;

    logic [7:0] r_out [3];
    logic       r_out_fe;
    logic       r_out_valid;

    logic        tap_wrap;
    logic        emit_now;
    logic [11:0] sum [3];
    logic [3:0]  cnt;
    logic [2:0]  rv, cv;
    logic [1:0]  nr, nc;
    logic [28:0] prod [3];
    logic [17:0] qd [3];
    logic [7:0]  res [3];

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = 11'd1;
        end else if ({21'd0, r_cfg_w} > MAXW32) begin
            w_eff = MAXW32[CFG_W_BITS-1:0];
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = 13'd1;
        end else if ({19'd0, r_cfg_h} > MAXH32) begin
            h_eff = MAXH32[CFG_H_BITS-1:0];
        end else begin
            h_eff = r_cfg_h;
        end
    end

    assign lag      = {1'b0, w_eff} + 12'd1;
    assign tap_wrap = ({{(32-AW){1'b0}}, r_tap} + 32'd1) == {21'd0, w_eff};
    assign emit_now = r_drain || (r_pend >= lag);

    assign o_status.pend_zero = (r_pend == '0);
    assign o_status.emit_now  = emit_now;
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_frame_width  = r_cfg_w;
    assign o_frame_height = r_cfg_h;

    // line stores: read at capture, written back at the shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_up_rd <= r_mem_up[r_tap];
            r_lo_rd <= r_mem_lo[r_tap];
        end
        if (i_ctl.shift) begin
            r_mem_up[r_tap] <= r_lo_rd;
            r_mem_lo[r_tap] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_drain <= (i_cmd == CMD_DRAIN);
            r_px    <= (i_cmd == CMD_DRAIN) ? '0 : {i_in_red, i_in_green, i_in_blue};
        end
    end

    // control counters and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RESET;
            r_cfg_h <= HEIGHT_RESET;
            r_tap   <= '0;
            r_pend  <= '0;
            r_icol  <= '0;
            r_irow  <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_WIDTH) begin
                r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
            end else begin
                r_cfg_h <= i_cfg_data[CFG_H_BITS-1:0];
            end
            r_tap  <= '0;
            r_pend <= '0;
            r_icol <= '0;
            r_irow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else if (i_ctl.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_lo_rd;
            r_win[2][2] <= r_px;
            r_tap <= tap_wrap ? '0 : r_tap + 1'b1;

            if (r_drain) begin
                r_pend <= r_pend - 1'b1;
            end else begin
                r_pend <= (r_pend >= lag) ? lag : r_pend + 1'b1;
                if (r_icol + 1'b1 >= w_eff) begin
                    r_icol <= '0;
                    r_irow <= (r_irow + 1'b1 >= h_eff) ? '0 : r_irow + 1'b1;
                end else begin
                    r_icol <= r_icol + 1'b1;
                end
            end

            // output position walks the frame once per result
            if (emit_now) begin
                if (r_ocol + 1'b1 >= w_eff) begin
                    r_ocol <= '0;
                    r_orow <= (r_orow + 1'b1 >= h_eff) ? '0 : r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_ecol <= r_ocol;
            r_erow <= r_orow;
        end
    end

    // in-bounds masks and masked sums
    always_comb begin
        rv[0] = (r_erow != '0);
        rv[1] = 1'b1;
        rv[2] = (r_erow != h_eff - 1'b1);
        cv[0] = (r_ecol != '0);
        cv[1] = 1'b1;
        cv[2] = (r_ecol != w_eff - 1'b1);
        nr    = 2'd1 + {1'b0, rv[0]} + {1'b0, rv[2]};
        nc    = 2'd1 + {1'b0, cv[0]} + {1'b0, cv[2]};
        cnt   = {2'b0, nr} * {2'b0, nc};
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (rv[r] && cv[c]) begin
                        sum[ch] = sum[ch] + {4'd0, r_win[r][c][8*(2-ch) +: 8]};
                    end
                end
            end
        end
    end

    // quotient of (2*sum + cnt) / (2*cnt): reciprocal estimate, then one fix-up
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = {16'd0, r_n[ch]} * {13'd0, r_m};
            qd[ch]   = {5'd0, r_q[ch]} * {13'd0, r_d2};
            res[ch]  = ({5'd0, r_n2[ch]} >= qd[ch] + {13'd0, r_d2}) ?
                       r_q[ch][7:0] + 8'd1 : r_q[ch][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_n[ch] <= {sum[ch], 1'b0} + {9'd0, cnt};
            end
            r_d  <= {cnt, 1'b0};
            r_m  <= bb3_recip(cnt);
            r_fe <= (r_erow == h_eff - 1'b1) && (r_ecol == w_eff - 1'b1);
        end
        if (i_ctl.mul) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_q[ch]  <= prod[ch][28:16];
                r_n2[ch] <= r_n[ch];
            end
            r_d2  <= r_d;
            r_fe2 <= r_fe;
        end
        if (i_ctl.load) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out[ch] <= res[ch];
            end
            r_out_fe <= r_fe2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_frame_end = r_out_fe;

endmodule

// File: src/box_blur_3x3_stream.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream
// 3x3 box blur over a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// An item that yields a result passes accept with line store read, window shift
// and store write-back, masked sum, reciprocal multiply and rounding fix-up into
// the output register; one that yields none ends after the shift, and a drain
// with nothing owed is taken and dropped. The sequencer handles one item at a
// time, and the next item is accepted while a finished result waits in the output
// register. Results lag their pixels by width+1 items; drains release the tail.
// Writing either register restarts the stream and drops owed results.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_frame_end
);

    t_bb3_cmd              ctl;
    t_bb3_status           status;
    logic                  cfg_we;
    logic [CFG_W_BITS-1:0] frame_width;
    logic [CFG_H_BITS-1:0] frame_height;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_IDX_HEIGHT) ? {19'd0, frame_height}
                                                 : {21'd0, frame_width};

    bb3_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (ctl)
    );

    bb3_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (paddr[2]),
        .i_cfg_data     (pwdata),
        .o_frame_width  (frame_width),
        .o_frame_height (frame_height),
        .i_cmd          (i_cmd),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .i_ctl          (ctl),
        .o_status       (status),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_frame_end    (o_frame_end)
    );

endmodule

// File: src/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_stream_defines.svh"

module bb3_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic       o_frame_end
);

    `BB3_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable({o_out_red, o_out_green, o_out_blue, o_frame_end}), "stalled result changed")
    `BB3_ASSERT(a_load_busy, i_clk, i_rst_n, $rose(o_valid) |-> $past(o_stall), "result appeared without a busy item")
    `BB3_ASSERT(a_accept_busy, i_clk, i_rst_n, $past(i_rst_n) && $fell(o_stall) |-> !$past(i_valid && !o_stall), "stall fell right after a transfer")
    `BB3_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid && !o_stall, "reset left output or stall set")
    `BB3_ASSERT_ALWAYS(a_pready, i_clk, pready, "pready dropped")

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 box blur stream: a local predictor tracks line
// stores, window and frame position, and every result transfer is compared with
// the oldest prediction. Covers default, tiny, clamped and random frame sizes.
// ----------------------------------------------------------------------------
module tb_top;
    import bb3_pkg::*;

    localparam int MAXW     = DEF_MAX_WIDTH;
    localparam int SETTLE   = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_blur_px;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid, o_stall, i_cmd;
    logic [7:0]  i_in_red, i_in_green, i_in_blue;
    logic        o_valid, i_stall;
    logic [7:0]  o_out_red, o_out_green, o_out_blue;
    logic        o_frame_end;

    box_blur_3x3_stream DUT (.*);

    // predictor state
    logic [23:0] upper_line [MAXW];
    logic [23:0] lower_line [MAXW];
    logic [23:0] win [3][3];
    int unsigned pix_col, pix_row, owed, tap;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    t_blur_px    blur_q[$];

    int n_err, n_items, n_results, n_frames_end;
    bit idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return height_reg;
    endfunction

    function automatic void window_shift(logic [23:0] px, int unsigned w);
        int unsigned t;
        logic [23:0] column [3];
        t = tap % w;
        column[0] = upper_line[t];
        column[1] = lower_line[t];
        column[2] = px;
        upper_line[t] = lower_line[t];
        lower_line[t] = px;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = column[r];
        end
        tap = (t + 1 == w) ? 0 : t + 1;
    endfunction

    // blurred value of the pixel that lags the current position by 'owed'
    function automatic void push_blur(int unsigned w, int unsigned h);
        int unsigned total, lin, o, cnt;
        int unsigned sum [3];
        int ro, co, r, c;
        t_blur_px e;
        total = w * h;
        lin = (pix_row % h) * w + (pix_col % w);
        o = (lin + total - (owed % total)) % total;
        ro = o / w;
        co = o % w;
        sum = '{0, 0, 0};
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                r = ro + dr;
                c = co + dc;
                if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
                    sum[0] += win[dr+1][dc+1][23:16];
                    sum[1] += win[dr+1][dc+1][15:8];
                    sum[2] += win[dr+1][dc+1][7:0];
                    cnt++;
                end
            end
        end
        e.red       = 8'((2 * sum[0] + cnt) / (2 * cnt));
        e.green     = 8'((2 * sum[1] + cnt) / (2 * cnt));
        e.blue      = 8'((2 * sum[2] + cnt) / (2 * cnt));
        e.frame_end = (ro == int'(h) - 1 && co == int'(w) - 1);
        blur_q.push_back(e);
    endfunction

    function automatic void predict_item(logic cmd, logic [23:0] px);
        int unsigned w, h;
        w = eff_w();
        h = eff_h();
        if (cmd == CMD_DRAIN) begin
            if (owed == 0) return;
            window_shift(24'd0, w);
            push_blur(w, h);
            owed--;
        end else begin
            window_shift(px, w);
            if (owed >= w + 1) begin
                owed = w + 1;
                push_blur(w, h);
            end else begin
                owed++;
            end
            pix_col++;
            if (pix_col >= w) begin
                pix_col = 0;
                pix_row++;
                if (pix_row >= h) pix_row = 0;
            end
        end
    endfunction

    function automatic void restart_stream();
        pix_col = 0;
        pix_row = 0;
        owed    = 0;
        tap     = 0;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        n_err++;
        if (n_err <= 10)
            $display("MISMATCH %s: expected %0h actual %0h at %0t", what, exp_v, act_v, $time);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_blur_px e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (blur_q.size() == 0) begin
                note_mismatch("unexpected result", 32'd0, {o_out_red, o_out_green, o_out_blue});
            end else begin
                e = blur_q.pop_front();
                if (o_out_red != e.red)     note_mismatch("red", e.red, o_out_red);
                if (o_out_green != e.green) note_mismatch("green", e.green, o_out_green);
                if (o_out_blue != e.blue)   note_mismatch("blue", e.blue, o_out_blue);
                if (o_frame_end != e.frame_end)
                    note_mismatch("frame_end", e.frame_end, o_frame_end);
                if (e.frame_end) n_frames_end++;
            end
        end
    end

    // result-side backpressure
    always @(posedge i_clk) begin
        i_stall <= idle_on ? ($urandom_range(99) < 21) : 1'b0;
    end

    task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (idle_on && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        do @(posedge i_clk); while (o_stall);
        predict_item(cmd, {r, g, b});
        n_items++;
    endtask

    task automatic send_pixel_rand();
        send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_drain();
        send_item(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic drain_all();
        while (owed > 0) send_drain();
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic idx, logic [31:0] data, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // write both registers, read them back
    task automatic set_frame(logic [10:0] w, logic [12:0] h);
        logic [31:0] rd;
        wait_quiet();
        apb_access(1'b1, CFG_IDX_WIDTH, 32'(w) | ($urandom & 32'hFFFF_F800), rd);
        width_reg = w;
        restart_stream();
        apb_access(1'b1, CFG_IDX_HEIGHT, 32'(h) | ($urandom & 32'hFFFF_E000), rd);
        height_reg = h;
        restart_stream();
        apb_access(1'b0, CFG_IDX_WIDTH, 32'd0, rd);
        if (rd[10:0] != w) note_mismatch("width readback", w, rd[10:0]);
        apb_access(1'b0, CFG_IDX_HEIGHT, 32'd0, rd);
        if (rd[12:0] != h) note_mismatch("height readback", h, rd[12:0]);
    endtask

    task automatic send_extreme_frame(int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            case (k % 4)
                0: send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
                1: send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
                2: send_item(CMD_PIXEL, 8'hFF, 8'h00, 8'hAA);
                default: send_item(CMD_PIXEL, 8'h01, 8'h80, 8'h55);
            endcase
    endtask

    // reset sizes, drains with and without owed results
    task automatic test_reset_defaults();
        send_drain();
        send_extreme_frame(6);
        drain_all();
        send_drain();
    endtask

    task automatic test_tiny_frames();
        set_frame(11'd3, 13'd3);
        send_extreme_frame(9);
        drain_all();
        set_frame(11'd0, 13'd0);    // zero sizes act as one
        send_extreme_frame(3);
        drain_all();
        set_frame(11'd1, 13'd5);
        send_extreme_frame(5);
        send_drain();               // partial drain, then more pixels
        send_extreme_frame(3);
        drain_all();
        set_frame(11'd5, 13'd1);
        send_extreme_frame(7);
        drain_all();
    endtask

    // oversized registers clamp to the maximum width and height
    task automatic test_clamped_frame();
        set_frame(11'h7FF, 13'h1FFF);
        for (int k = 0; k < 8; k++) send_pixel_rand();
        drain_all();
        set_frame(11'd1024, 13'd2);
        for (int k = 0; k < 8; k++) send_pixel_rand();
        drain_all();
    endtask

    task automatic test_random_streams();
        int start, w, h, frames;
        start = n_items;
        idle_on = 1'b0;             // long stretch without gaps first
        while (n_items - start < 600) begin
            if (n_items - start > 150) idle_on = 1'b1;
            w = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            set_frame(11'(w), 13'(h));
            frames = $urandom_range(1, 3);
            for (int k = 0; k < frames * (w == 0 ? 1 : w) * (h == 0 ? 1 : h); k++) begin
                if ($urandom_range(99) < 8) send_drain();
                send_pixel_rand();
            end
            if ($urandom_range(1)) drain_all();
            else repeat ($urandom_range(0, 3)) send_drain();
            if ($urandom_range(3) == 0) send_drain();
        end
        drain_all();
        idle_on = 1'b1;
    endtask

    initial begin
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_cmd = CMD_PIXEL;
        i_in_red = '0; i_in_green = '0; i_in_blue = '0;
        i_stall = 1'b0;
        i_rst_n = 1'b0;
        idle_on = 1'b1;
        n_err = 0; n_items = 0; n_results = 0; n_frames_end = 0;
        for (int k = 0; k < MAXW; k++) begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        win = '{default: '0};
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        restart_stream();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_tiny_frames();
        test_clamped_frame();
        test_random_streams();

        i_valid <= 1'b0;
        fork
            while (blur_q.size() != 0) @(posedge i_clk);
            repeat (200000) @(posedge i_clk);
        join_any
        disable fork;
        repeat (SETTLE) @(posedge i_clk);
        if (blur_q.size() != 0) note_mismatch("results never delivered", blur_q.size(), 0);
        $display("Run covered %0d items, %0d blurred pixels checked, %0d frame ends.",
                 n_items, n_results, n_frames_end);
        $display("Frame sizes: reset default, 1x1 to 20x6, oversized registers; %0d mismatches.",
                 n_err);
        if (n_err == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", blur_q.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
